// ===== rtl/spd_pkg.sv =====
// ============================================================================
// spd_pkg
// Shared types and constants of the sensor packet deframer.
// ============================================================================
package spd_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int YAW_W     = 16;
    localparam int CFG_IDX_W = 8;

    // Byte positions inside a packet.
    localparam int TYPE_POS   = 1;
    localparam int YAW_LO_POS = 6;
    localparam int YAW_HI_POS = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_IDX = 8'd1;

    // Register reset values.
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] WANTED_RESET = 8'h53;

    // Per-cycle control handed to every window cell.
    typedef struct packed {
        logic load;   // store the incoming byte in this cell
        logic shift;  // take the byte from the realigned source position
    } spd_cell_ctl_t;

endpackage

// ===== rtl/spd_cell.sv =====
// ============================================================================
// spd_cell
// One window cell: holds one packet byte and the running sum up to it.
// ============================================================================
module spd_cell
    import spd_pkg::*;
(
    input  logic                aclk,
    input  spd_cell_ctl_t       ctl,
    input  logic [BYTE_W-1:0]   load_byte,
    input  logic [BYTE_W-1:0]   load_pre,
    input  logic [BYTE_W-1:0]   shift_byte,
    input  logic [BYTE_W-1:0]   shift_pre,
    input  logic [BYTE_W-1:0]   base_pre,
    output logic [BYTE_W-1:0]   byte_out,
    output logic [BYTE_W-1:0]   pre_out
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic [BYTE_W-1:0] pre_reg;
    logic [BYTE_W-1:0] pre_next;

    // On realignment the prefix sum is rebased to the new head byte.
    always_comb begin
        byte_next = byte_reg;
        pre_next  = pre_reg;
        if (ctl.load) begin
            byte_next = load_byte;
            pre_next  = load_pre;
        end else if (ctl.shift) begin
            byte_next = shift_byte;
            pre_next  = shift_pre - base_pre;
        end
    end

    // Payload storage, no reset needed.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        pre_reg  <= pre_next;
    end

    assign byte_out = byte_reg;
    assign pre_out  = pre_reg;

endmodule

// ===== rtl/sensor_packet_deframer_top.sv =====
// ============================================================================
// sensor_packet_deframer_top
// Recovers checksummed sensor packets from a byte stream and emits yaw codes.
// ============================================================================
//
//  Channel  Direction  Payload                       Transaction when
//  s_       in         tdata[7:0]  rx_byte           s_tvalid && s_tready
//  m_       out        tdata[15:0] yaw_code          m_tvalid && m_tready
//  cfg_     in         index[7:0], data[7:0]         cfg_valid && cfg_ready
//
//  One byte is taken every cycle while s_tready is high; a packet check, its
//  result and any realignment finish in the cycle of the last byte, through one
//  add and one parallel header search over the cell row followed by a variable
//  shift. A result is registered and shows on m_ in the cycle after the final
//  byte. s_tready drops only while a result waits and m_tready is low.
//  Reset is synchronous on aresetn; it clears the fill count, sum and output
//  valid, presets the configuration registers; window bytes are not cleared.
//
module sensor_packet_deframer_top
    import spd_pkg::*;
#(
    parameter int PACKET_LEN = 11
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream; tdata[7:0] = rx_byte.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    // Result stream; tdata[15:0] = yaw_code.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [YAW_W-1:0]      m_tdata,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data
);

    localparam int IDX_W  = $clog2(PACKET_LEN);
    localparam int NCELL  = PACKET_LEN - 1;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(PACKET_LEN - 1);

    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] wanted_reg;
    logic [IDX_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  fill_next;
    logic [BYTE_W-1:0] total_reg;
    logic [BYTE_W-1:0] total_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [YAW_W-1:0]  out_data_reg;
    logic [YAW_W-1:0]  out_data_next;

    logic              accept;
    logic              take;
    logic              full_evt;
    logic              append;
    logic              sum_ok;
    logic              realign;
    logic              hit;
    logic              found;
    logic [IDX_W-1:0]  sel;
    logic [IDX_W-1:0]  base_idx;
    logic [BYTE_W-1:0] base_pre;
    logic [BYTE_W-1:0] sum_in;

    logic [BYTE_W-1:0] cell_byte [NCELL];
    logic [BYTE_W-1:0] cell_pre  [NCELL];
    logic [BYTE_W-1:0] ext_byte  [PACKET_LEN];
    logic [BYTE_W-1:0] ext_pre   [PACKET_LEN];

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // A byte is kept unless it arrives on an empty window and is no header.
    assign take     = accept && !((fill_reg == '0) && (s_tdata != header_reg));
    assign full_evt = take && (fill_reg == LAST_POS);
    assign append   = take && !full_evt;
    assign sum_in   = total_reg + s_tdata;
    assign sum_ok   = (total_reg == s_tdata);
    assign hit      = full_evt && sum_ok && (ext_byte[TYPE_POS] == wanted_reg);
    assign realign  = full_evt && !sum_ok && found;

    // Full packet view: stored cells plus the incoming checksum byte.
    always_comb begin
        for (int j = 0; j < NCELL; j++) begin
            ext_byte[j] = cell_byte[j];
            ext_pre[j]  = cell_pre[j];
        end
        ext_byte[PACKET_LEN-1] = s_tdata;
        ext_pre[PACKET_LEN-1]  = sum_in;
    end

    // First header after the head byte; the lowest match wins.
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int j = PACKET_LEN - 1; j >= 1; j--) begin
            if (ext_byte[j] == header_reg) begin
                found = 1'b1;
                sel   = IDX_W'(j);
            end
        end
        base_idx = found ? IDX_W'(sel - 1'b1) : '0;
        base_pre = ext_pre[base_idx];
    end

    // Row of window cells.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        spd_cell_ctl_t              ctl;
        logic [IDX_W:0]             src;
        logic [BYTE_W-1:0]          shift_byte;
        logic [BYTE_W-1:0]          shift_pre;

        assign ctl.load  = append && (fill_reg == IDX_W'(k));
        assign ctl.shift = realign;

        // Source of this cell after moving the found header to the head.
        always_comb begin
            src = {1'b0, sel} + (IDX_W + 1)'(k);
            if (src < (IDX_W + 1)'(PACKET_LEN)) begin
                shift_byte = ext_byte[src[IDX_W-1:0]];
                shift_pre  = ext_pre[src[IDX_W-1:0]];
            end else begin
                shift_byte = '0;
                shift_pre  = '0;
            end
        end

        spd_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .load_byte  (s_tdata),
            .load_pre   (sum_in),
            .shift_byte (shift_byte),
            .shift_pre  (shift_pre),
            .base_pre   (base_pre),
            .byte_out   (cell_byte[k]),
            .pre_out    (cell_pre[k])
        );
    end

    // Fill count and running sum of the held bytes.
    always_comb begin
        fill_next  = fill_reg;
        total_next = total_reg;
        if (append) begin
            fill_next  = fill_reg + 1'b1;
            total_next = sum_in;
        end else if (full_evt) begin
            if (realign) begin
                fill_next  = IDX_W'(PACKET_LEN - int'(sel));
                total_next = sum_in - base_pre;
            end else begin
                fill_next  = '0;
                total_next = '0;
            end
        end
    end

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (hit) begin
            out_valid_next = 1'b1;
            out_data_next  = {ext_byte[YAW_HI_POS], ext_byte[YAW_LO_POS]};
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            header_reg    <= HEADER_RESET;
            wanted_reg    <= WANTED_RESET;
        end else begin
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HEADER_IDX: header_reg <= cfg_data;
                    CFG_WANTED_IDX: wanted_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/spd_checker.sv =====
// ============================================================================
// spd_checker
// Port-level checks of the sensor packet deframer, bound to the top level.
// ============================================================================
module spd_checker
    import spd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [YAW_W-1:0]      m_tdata
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input is held off only by a waiting result.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output slot");

    // A new result needs an input transaction in the previous cycle.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without input transaction");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sensor_packet_deframer_top spd_checker u_spd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sensor_packet_deframer_top_tb.sv =====
// ============================================================================
// sensor_packet_deframer_top_tb
// Self-checking bench for the sensor packet deframer: a byte stream of
// well-formed, corrupted, truncated and noise packets is driven into the
// block, a behavioral deframer predicts every yaw code, and each result
// transaction is compared with the oldest prediction.
// ============================================================================
module sensor_packet_deframer_top_tb;
    import spd_pkg::*;

    localparam int PKT_LEN      = 11;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_BYTES  = 115;

    // Register indexes that name no register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX    = 8'hFF;

    // Behavioral deframer and the queue of yaw codes still due.
    class yaw_scoreboard;
        logic [BYTE_W-1:0] header_val;
        logic [BYTE_W-1:0] wanted_val;
        logic [BYTE_W-1:0] window [PKT_LEN];
        int unsigned       fill;
        logic [YAW_W-1:0]  yaw_due [$];
        int                errors;

        function new();
            header_val = HEADER_RESET;
            wanted_val = WANTED_RESET;
            fill       = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            if (idx == CFG_HEADER_IDX) begin
                header_val = val;
            end else if (idx == CFG_WANTED_IDX) begin
                wanted_val = val;
            end
        endfunction

        function int pending();
            return yaw_due.size();
        endfunction

        // Advance the window by one accepted byte.
        function void note_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] sum;
            bit                found;
            sum   = '0;
            found = 0;
            if (fill == 0 && b != header_val) begin
                return;
            end
            if (fill >= PKT_LEN) begin
                fill = 0;
            end
            window[fill] = b;
            fill++;
            if (fill < PKT_LEN) begin
                return;
            end
            for (int i = 0; i < PKT_LEN - 1; i++) begin
                sum = sum + window[i];
            end
            if (sum == window[PKT_LEN-1]) begin
                fill = 0;
                if (window[TYPE_POS] == wanted_val) begin
                    yaw_due.push_back({window[YAW_HI_POS], window[YAW_LO_POS]});
                end
                return;
            end
            // Bad checksum: drop the head and slide to the next header, if any.
            for (int i = 1; i < PKT_LEN; i++) begin
                if (!found && window[i] == header_val) begin
                    for (int k = 0; k + i < PKT_LEN; k++) begin
                        window[k] = window[k+i];
                    end
                    fill  = PKT_LEN - i;
                    found = 1;
                end
            end
            if (!found) begin
                fill = 0;
            end
        endfunction

        function void check_yaw(logic [YAW_W-1:0] got);
            logic [YAW_W-1:0] want;
            if (yaw_due.size() == 0) begin
                $error("yaw_code: expected none, actual %h", got);
                errors++;
                return;
            end
            want = yaw_due.pop_front();
            if (got !== want) begin
                $error("yaw_code: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;     // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [YAW_W-1:0]     m_tdata;     // [15:0] yaw_code
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    yaw_scoreboard     sb = new();
    int                src_idle  = 0;
    int                sink_idle = 0;
    int                hold_id   = 0;
    logic [BYTE_W-1:0] cur_hdr   = HEADER_RESET;
    logic [BYTE_W-1:0] cur_wanted = WANTED_RESET;
    logic [BYTE_W-1:0] pkt_buf [PKT_LEN];

    sensor_packet_deframer_top #(.PACKET_LEN(PKT_LEN)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Check result transactions first, then feed input transactions forward.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_yaw(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_id != hold_seen) begin
                hold_seen = hold_id;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    // Random byte that hits the current header often enough to exercise realignment.
    function automatic logic [BYTE_W-1:0] rand_byte();
        if ($urandom_range(7) == 0) begin
            return cur_hdr;
        end
        return BYTE_W'($urandom_range(255));
    endfunction

    // Fill pkt_buf with one packet; a corrupted one gets a checksum that is off.
    function automatic void build_packet(logic [BYTE_W-1:0] typ, logic [YAW_W-1:0] yaw,
                                         bit corrupt);
        logic [BYTE_W-1:0] sum;
        sum = '0;
        pkt_buf[0] = cur_hdr;
        for (int i = 1; i < PKT_LEN - 1; i++) begin
            pkt_buf[i] = rand_byte();
        end
        pkt_buf[TYPE_POS]   = typ;
        pkt_buf[YAW_LO_POS] = yaw[7:0];
        pkt_buf[YAW_HI_POS] = yaw[15:8];
        for (int i = 0; i < PKT_LEN - 1; i++) begin
            sum = sum + pkt_buf[i];
        end
        pkt_buf[PKT_LEN-1] = corrupt ? sum + BYTE_W'($urandom_range(1, 255)) : sum;
    endfunction

    // Entered just after a falling edge; returns just after a falling edge.
    task automatic send_byte(logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_packet_bytes(int n);
        for (int i = 0; i < n; i++) begin
            send_byte(pkt_buf[i]);
        end
    endtask

    // Stop offering bytes and wait until every yaw code has arrived.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        if (idx == CFG_HEADER_IDX) begin
            cur_hdr = val;
        end else if (idx == CFG_WANTED_IDX) begin
            cur_wanted = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // One random stimulus step; returns the number of packet bytes offered.
    task automatic random_step(output int n);
        int               pick;
        logic [BYTE_W-1:0] typ;
        pick = $urandom_range(99);
        typ  = ($urandom_range(4) != 0) ? cur_wanted : rand_byte();
        n    = 0;
        if (pick < 60) begin
            build_packet(typ, YAW_W'($urandom_range(65535)), 1'b0);
            send_packet_bytes(PKT_LEN);
            n = PKT_LEN;
        end else if (pick < 72) begin
            build_packet(typ, YAW_W'($urandom_range(65535)), 1'b1);
            send_packet_bytes(PKT_LEN);
            n = PKT_LEN;
        end else if (pick < 84) begin
            // Truncated packet: the next header lands inside this window.
            build_packet(typ, YAW_W'($urandom_range(65535)), 1'b0);
            n = $urandom_range(1, PKT_LEN - 1);
            send_packet_bytes(n);
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
        end
    endtask

    initial begin
        int sent;
        int n;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle  = 31;
        sink_idle = 86;

        // Writes to indexes outside the register list change nothing.
        write_reg(CFG_UNUSED_IDX, BYTE_W'($urandom_range(255)));
        write_reg(CFG_TOP_IDX, BYTE_W'($urandom_range(255)));

        // Directed: stray bytes, a good packet, a bad one with a header inside.
        send_byte(8'h00);
        send_byte(8'hFF);
        build_packet(cur_wanted, 16'hFF00, 1'b0);
        send_packet_bytes(PKT_LEN);
        build_packet(cur_wanted, YAW_W'($urandom_range(65535)), 1'b1);
        pkt_buf[4] = cur_hdr;
        send_packet_bytes(PKT_LEN);

        // Change the header while a partial packet sits in the window.
        build_packet(cur_wanted, 16'h00FF, 1'b0);
        send_packet_bytes(3);
        wait_drain();
        write_reg(CFG_HEADER_IDX, 8'hA5);
        write_reg(CFG_WANTED_IDX, 8'h51);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                wait_drain();
                write_reg(CFG_HEADER_IDX, 8'h00);
                write_reg(CFG_WANTED_IDX, 8'hFF);
                src_idle  = 86;
                sink_idle = 31;
            end else if (phase == 2) begin
                wait_drain();
                write_reg(CFG_HEADER_IDX, 8'hFF);
                write_reg(CFG_WANTED_IDX, 8'h00);
                src_idle  = 0;
                sink_idle = 0;
                // Long receiver hold-off while good packets keep coming.
                hold_id++;
                repeat (5) begin
                    build_packet(cur_wanted, YAW_W'($urandom_range(65535)), 1'b0);
                    send_packet_bytes(PKT_LEN);
                end
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                random_step(n);
                sent += n;
                if ($urandom_range(39) == 0) begin
                    wait_drain();
                end
            end
        end

        wait_drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sensor_packet_deframer_top.f =====
rtl/spd_pkg.sv
rtl/spd_cell.sv
rtl/sensor_packet_deframer_top.sv
rtl/spd_checker.sv
tb/sensor_packet_deframer_top_tb.sv
